@@ sv/cmpa_pkg.sv @@
// Shared types and constants for the cubic motion profile axis.
// Used by the sequencer top level, the serial multiplier, the serial divider and the checker.
`default_nettype none
package cmpa_pkg;

	localparam int POS_WIDTH      = 32;
	localparam int TIME_WIDTH     = 24;
	localparam int COEF_WIDTH     = 48;
	localparam int FRAC_BITS      = 16;
	localparam int ELAP_WIDTH     = TIME_WIDTH + 1;
	localparam int LEFT_WIDTH     = TIME_WIDTH + 2;
	localparam int OP_WIDTH       = 64;
	localparam int QUO_WIDTH      = 62;
	localparam int SHIFT_WIDTH    = $clog2(2 * FRAC_BITS + 1);
	localparam int DIV_CNT_WIDTH  = $clog2(OP_WIDTH + 2 * FRAC_BITS);
	localparam int CFG_IDX_WIDTH  = 3;
	localparam int CFG_DATA_WIDTH = 32;
	localparam int IN_DATA_WIDTH  = ((TIME_WIDTH + 7) / 8) * 8;
	localparam int OUT_DATA_WIDTH = ((2 * POS_WIDTH + LEFT_WIDTH + 7) / 8) * 8;

	// saturation magnitude of divider quotients and of the jerk times tau cubed term
	localparam logic [QUO_WIDTH-1:0] SATMAG = '1;

	localparam logic MODE_START   = 1'b0;
	localparam logic MODE_ADVANCE = 1'b1;

	typedef enum logic [CFG_IDX_WIDTH-1:0] {
		REG_PATH_TIME,
		REG_START_POS,
		REG_START_VEL,
		REG_END_POS,
		REG_END_VEL,
		REG_MOVE_REL
	} cfg_reg_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_START,
		ST_N_MUL,
		ST_DIV1,
		ST_DIV2,
		ST_DIV3,
		ST_JT_MUL,
		ST_E_DIV,
		ST_TICK,
		ST_T2_MUL,
		ST_T3_MUL,
		ST_AT_MUL,
		ST_JT2_MUL,
		ST_VT_MUL,
		ST_AT2_MUL,
		ST_JT3_MUL,
		ST_DIV6,
		ST_FINISH,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic                start;
		logic [OP_WIDTH-1:0] a;
		logic [OP_WIDTH-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic                  done;
		logic [2*OP_WIDTH-1:0] prod;
	} mul_rsp_t;

	typedef struct packed {
		logic                   start;
		logic [OP_WIDTH-1:0]    num;
		logic [SHIFT_WIDTH-1:0] shift;
		logic [TIME_WIDTH-1:0]  den;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [QUO_WIDTH-1:0] quo;
	} div_rsp_t;

endpackage
`default_nettype wire

@@ sv/cubic_motion_profile_axis.sv @@
// One axis of a cubic motion segment. A word with tuser = 0 starts a segment: elapsed time
// clears, the target is latched and, for a nonzero path time, jerk and acceleration are
// solved; its result is the start position, start velocity and path time. A word with
// tuser = 1 advances time by tdata and returns position, velocity and time left, holding
// the end values once no time is left. All products and quotients go through one bit-serial
// 64-bit multiplier and one bit-serial restoring divider that appends fraction bits to the
// dividend; a start with zero path time or a tick past the end uses neither and goes
// straight to output. The result word is registered before it is presented.
// One item is in work at a time; the result register lets the next item be accepted while
// the previous result waits, and a finished item holds in its last state while it does.
`default_nettype none
module cubic_motion_profile_axis (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [cmpa_pkg::IN_DATA_WIDTH-1:0]    s_axis_tdata,  // frame_time
	input  logic                                  s_axis_tuser,  // mode
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	output logic [cmpa_pkg::OUT_DATA_WIDTH-1:0]   m_axis_tdata,  // position, velocity, time_left
	input  logic                                  cfg_we,
	input  logic [cmpa_pkg::CFG_IDX_WIDTH-1:0]    cfg_index,
	input  logic [cmpa_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);
	import cmpa_pkg::*;

	localparam int PAD_WIDTH = OUT_DATA_WIDTH - 2 * POS_WIDTH - LEFT_WIDTH;

	function automatic logic [COEF_WIDTH-1:0] sat_coef(input logic [63:0] x);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = (64'sd1 <<< (COEF_WIDTH - 1)) - 64'sd1;
		lo = -hi - 64'sd1;
		if ($signed(x) > hi)
			return hi[COEF_WIDTH-1:0];
		else if ($signed(x) < lo)
			return lo[COEF_WIDTH-1:0];
		else
			return x[COEF_WIDTH-1:0];
	endfunction

	// truncate toward zero at 16 fraction bits, then saturate
	function automatic logic [POS_WIDTH-1:0] fin_pos(input logic [63:0] x);
		logic signed [63:0] bias;
		logic signed [63:0] y;
		logic signed [63:0] hi;
		bias = x[63] ? ((64'sd1 <<< FRAC_BITS) - 64'sd1) : 64'sd0;
		y    = ($signed(x) + bias) >>> FRAC_BITS;
		hi   = (64'sd1 <<< (POS_WIDTH - 1)) - 64'sd1;
		if (y > hi)
			return hi[POS_WIDTH-1:0];
		else if (y < -hi - 64'sd1)
			return {1'b1, {(POS_WIDTH-1){1'b0}}};
		else
			return y[POS_WIDTH-1:0];
	endfunction

	function automatic logic [63:0] apply_sign(input logic neg, input logic [63:0] mag);
		return neg ? (64'd0 - mag) : mag;
	endfunction

	// configuration
	logic [TIME_WIDTH-1:0] path_time_q;
	logic [POS_WIDTH-1:0]  start_pos_q;
	logic [POS_WIDTH-1:0]  start_vel_q;
	logic [POS_WIDTH-1:0]  end_pos_q;
	logic [POS_WIDTH-1:0]  end_vel_q;
	logic                  move_rel_q;

	// segment state
	logic [ELAP_WIDTH-1:0] elapsed_q;
	logic [COEF_WIDTH-1:0] jerk_q;
	logic [COEF_WIDTH-1:0] accel_q;
	logic [POS_WIDTH-1:0]  target_q;

	// working registers
	state_t                state_q;
	state_t                state_next;
	logic                  issued_q;
	logic [TIME_WIDTH-1:0] ft_q;
	logic [63:0]           wrk_q;
	logic                  neg_q;
	logic [63:0]           jt_q;
	logic [63:0]           vsum_q;
	logic [63:0]           psum_q;
	logic [2*TIME_WIDTH-1:0] t2_q;
	logic [55:0]           t3_q;
	logic [POS_WIDTH-1:0]  pos_q;
	logic [POS_WIDTH-1:0]  vel_q;
	logic [LEFT_WIDTH-1:0] left_q;
	logic                  m_valid_q;
	logic [OUT_DATA_WIDTH-1:0] m_data_q;

	mul_req_t mul_req;
	mul_rsp_t mul_rsp;
	div_req_t div_req;
	div_rsp_t div_rsp;
	logic     mul_op;
	logic     div_op;
	logic     op_done;
	logic     out_load;
	logic     in_take;

	// combinational helpers
	logic [POS_WIDTH:0]    rel_sum;
	logic [POS_WIDTH-1:0]  rel_target;
	logic [POS_WIDTH:0]    p_diff;
	logic [POS_WIDTH:0]    v_sum;
	logic [POS_WIDTH:0]    e_dif;
	logic [POS_WIDTH:0]    v_mag;
	logic [POS_WIDTH:0]    e_mag;
	logic [TIME_WIDTH+2:0] t6;
	logic [63:0]           p_ext;
	logic [63:0]           p12;
	logic [63:0]           n_val;
	logic [COEF_WIDTH-1:0] a_mag;
	logic [COEF_WIDTH-1:0] j_mag;
	logic [POS_WIDTH-1:0]  vs_mag;
	logic [63:0]           vs_shift;
	logic [63:0]           ps_shift;
	logic [ELAP_WIDTH:0]   el_sum;
	logic [ELAP_WIDTH-1:0] el_new;
	logic [LEFT_WIDTH-1:0] left_new;
	logic                  left_pos;
	logic [63:0]           jt3_term;

	assign rel_sum    = {start_pos_q[POS_WIDTH-1], start_pos_q}
		+ {end_pos_q[POS_WIDTH-1], end_pos_q};
	assign rel_target = (rel_sum[POS_WIDTH] != rel_sum[POS_WIDTH-1])
		? {rel_sum[POS_WIDTH], {(POS_WIDTH-1){~rel_sum[POS_WIDTH]}}}
		: rel_sum[POS_WIDTH-1:0];

	assign p_diff = {target_q[POS_WIDTH-1], target_q} - {start_pos_q[POS_WIDTH-1], start_pos_q};
	assign v_sum  = {end_vel_q[POS_WIDTH-1], end_vel_q} + {start_vel_q[POS_WIDTH-1], start_vel_q};
	assign e_dif  = {end_vel_q[POS_WIDTH-1], end_vel_q} - {start_vel_q[POS_WIDTH-1], start_vel_q};
	assign v_mag  = v_sum[POS_WIDTH] ? (~v_sum + 1'b1) : v_sum;
	assign e_mag  = e_dif[POS_WIDTH] ? (~e_dif + 1'b1) : e_dif;
	assign t6     = {1'b0, path_time_q, 2'b00} + {2'b00, path_time_q, 1'b0};
	assign p_ext  = {{(63-POS_WIDTH){p_diff[POS_WIDTH]}}, p_diff};
	assign p12    = (p_ext << (FRAC_BITS + 3)) + (p_ext << (FRAC_BITS + 2));
	assign n_val  = apply_sign(v_sum[POS_WIDTH], mul_rsp.prod[63:0]) - p12;

	assign a_mag    = accel_q[COEF_WIDTH-1] ? (~accel_q + 1'b1) : accel_q;
	assign j_mag    = jerk_q[COEF_WIDTH-1] ? (~jerk_q + 1'b1) : jerk_q;
	assign vs_mag   = start_vel_q[POS_WIDTH-1] ? (~start_vel_q + 1'b1) : start_vel_q;
	assign vs_shift = {{(64-POS_WIDTH-FRAC_BITS){start_vel_q[POS_WIDTH-1]}}, start_vel_q,
		{FRAC_BITS{1'b0}}};
	assign ps_shift = {{(64-POS_WIDTH-FRAC_BITS){start_pos_q[POS_WIDTH-1]}}, start_pos_q,
		{FRAC_BITS{1'b0}}};

	assign el_sum   = {1'b0, elapsed_q} + (ELAP_WIDTH+1)'(ft_q);
	assign el_new   = el_sum[ELAP_WIDTH] ? {ELAP_WIDTH{1'b1}} : el_sum[ELAP_WIDTH-1:0];
	assign left_new = {2'b00, path_time_q} - {1'b0, el_new};
	assign left_pos = !left_new[LEFT_WIDTH-1] && (left_new != '0);

	// jerk times tau cubed, saturated before the division by six
	assign jt3_term = (mul_rsp.prod[127:94] != '0) ? {2'b00, SATMAG}
		: {2'b00, mul_rsp.prod[93:32]};

	assign in_take = s_axis_tvalid && s_axis_tready;

	cmpa_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	cmpa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid)
					state_next = (s_axis_tuser == MODE_START) ? ST_START : ST_TICK;
			end
			ST_START:   state_next = (path_time_q == '0) ? ST_OUT : ST_N_MUL;
			ST_N_MUL:   if (op_done) state_next = ST_DIV1;
			ST_DIV1:    if (op_done) state_next = ST_DIV2;
			ST_DIV2:    if (op_done) state_next = ST_DIV3;
			ST_DIV3:    if (op_done) state_next = ST_JT_MUL;
			ST_JT_MUL:  if (op_done) state_next = ST_E_DIV;
			ST_E_DIV:   if (op_done) state_next = ST_OUT;
			ST_TICK:    state_next = left_pos ? ST_T2_MUL : ST_OUT;
			ST_T2_MUL:  if (op_done) state_next = ST_T3_MUL;
			ST_T3_MUL:  if (op_done) state_next = ST_AT_MUL;
			ST_AT_MUL:  if (op_done) state_next = ST_JT2_MUL;
			ST_JT2_MUL: if (op_done) state_next = ST_VT_MUL;
			ST_VT_MUL:  if (op_done) state_next = ST_AT2_MUL;
			ST_AT2_MUL: if (op_done) state_next = ST_JT3_MUL;
			ST_JT3_MUL: if (op_done) state_next = ST_DIV6;
			ST_DIV6:    if (op_done) state_next = ST_FINISH;
			ST_FINISH:  state_next = ST_OUT;
			ST_OUT:     if (!m_valid_q || m_axis_tready) state_next = ST_IDLE;
			default:    state_next = ST_IDLE;
		endcase
	end

	// outputs and unit requests
	always_comb begin
		s_axis_tready = 1'b0;
		out_load      = 1'b0;
		mul_op        = 1'b0;
		div_op        = 1'b0;
		mul_req.a     = '0;
		mul_req.b     = '0;
		div_req.num   = wrk_q;
		div_req.shift = SHIFT_WIDTH'(FRAC_BITS);
		div_req.den   = path_time_q;
		case (state_q)
			ST_IDLE: s_axis_tready = 1'b1;
			ST_N_MUL: begin
				mul_op    = 1'b1;
				mul_req.a = 64'(v_mag);
				mul_req.b = 64'(t6);
			end
			ST_DIV1, ST_DIV2, ST_DIV3: div_op = 1'b1;
			ST_JT_MUL: begin
				mul_op    = 1'b1;
				mul_req.a = 64'(j_mag);
				mul_req.b = 64'(path_time_q);
			end
			ST_E_DIV: begin
				div_op        = 1'b1;
				div_req.num   = 64'(e_mag);
				div_req.shift = SHIFT_WIDTH'(2 * FRAC_BITS);
			end
			ST_T2_MUL: begin
				mul_op    = 1'b1;
				mul_req.a = 64'(elapsed_q);
				mul_req.b = 64'(elapsed_q);
			end
			ST_T3_MUL: begin
				mul_op    = 1'b1;
				mul_req.a = 64'(t2_q);
				mul_req.b = 64'(elapsed_q);
			end
			ST_AT_MUL: begin
				mul_op    = 1'b1;
				mul_req.a = 64'(a_mag);
				mul_req.b = 64'(elapsed_q);
			end
			ST_JT2_MUL: begin
				mul_op    = 1'b1;
				mul_req.a = 64'(j_mag);
				mul_req.b = 64'(t2_q);
			end
			ST_VT_MUL: begin
				mul_op    = 1'b1;
				mul_req.a = 64'(vs_mag);
				mul_req.b = 64'(elapsed_q);
			end
			ST_AT2_MUL: begin
				mul_op    = 1'b1;
				mul_req.a = 64'(a_mag);
				mul_req.b = 64'(t2_q);
			end
			ST_JT3_MUL: begin
				mul_op    = 1'b1;
				mul_req.a = 64'(j_mag);
				mul_req.b = 64'(t3_q);
			end
			ST_DIV6: begin
				div_op        = 1'b1;
				div_req.shift = '0;
				div_req.den   = TIME_WIDTH'(6);
			end
			ST_OUT: out_load = !m_valid_q || m_axis_tready;
			default: ;
		endcase
		mul_req.start = mul_op && !issued_q;
		div_req.start = div_op && !issued_q;
		op_done       = (mul_op && mul_rsp.done) || (div_op && div_rsp.done);
	end

	// control and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			issued_q    <= 1'b0;
			m_valid_q   <= 1'b0;
			path_time_q <= '0;
			start_pos_q <= '0;
			start_vel_q <= '0;
			end_pos_q   <= '0;
			end_vel_q   <= '0;
			move_rel_q  <= 1'b0;
		end else begin
			state_q <= state_next;
			if (mul_req.start || div_req.start)
				issued_q <= 1'b1;
			else if (op_done)
				issued_q <= 1'b0;
			if (out_load)
				m_valid_q <= 1'b1;
			else if (m_axis_tready)
				m_valid_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_PATH_TIME: path_time_q <= cfg_data[TIME_WIDTH-1:0];
					REG_START_POS: start_pos_q <= cfg_data[POS_WIDTH-1:0];
					REG_START_VEL: start_vel_q <= cfg_data[POS_WIDTH-1:0];
					REG_END_POS:   end_pos_q   <= cfg_data[POS_WIDTH-1:0];
					REG_END_VEL:   end_vel_q   <= cfg_data[POS_WIDTH-1:0];
					REG_MOVE_REL:  move_rel_q  <= cfg_data[0];
					default: ;
				endcase
			end
		end
	end

	// segment state, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q <= '0;
			jerk_q    <= '0;
			accel_q   <= '0;
			target_q  <= '0;
		end else begin
			case (state_q)
				ST_START: begin
					elapsed_q <= '0;
					target_q  <= move_rel_q ? rel_target : end_pos_q;
				end
				ST_DIV3:  if (op_done) jerk_q <= sat_coef(apply_sign(neg_q, 64'(div_rsp.quo)));
				ST_E_DIV: begin
					if (op_done)
						accel_q <= sat_coef(apply_sign(e_dif[POS_WIDTH], 64'(div_rsp.quo)) - jt_q);
				end
				ST_TICK:  elapsed_q <= el_new;
				default: ;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (in_take)
			ft_q <= s_axis_tdata[TIME_WIDTH-1:0];
		case (state_q)
			ST_START: begin
				pos_q  <= start_pos_q;
				vel_q  <= start_vel_q;
				left_q <= {2'b00, path_time_q};
			end
			ST_N_MUL: begin
				if (op_done) begin
					wrk_q <= apply_sign(n_val[63], n_val);
					neg_q <= n_val[63];
				end
			end
			ST_DIV1, ST_DIV2: if (op_done) wrk_q <= 64'(div_rsp.quo);
			ST_JT_MUL: begin
				if (op_done)
					jt_q <= apply_sign(jerk_q[COEF_WIDTH-1], mul_rsp.prod[80:17]);
			end
			ST_TICK: begin
				left_q <= left_new;
				if (!left_pos) begin
					pos_q <= target_q;
					vel_q <= end_vel_q;
				end
			end
			ST_T2_MUL:  if (op_done) t2_q <= mul_rsp.prod[2*TIME_WIDTH-1:0];
			ST_T3_MUL:  if (op_done) t3_q <= mul_rsp.prod[71:16];
			ST_AT_MUL: begin
				if (op_done)
					vsum_q <= vs_shift
						+ apply_sign(accel_q[COEF_WIDTH-1], 64'(mul_rsp.prod[71:16]));
			end
			ST_JT2_MUL: begin
				if (op_done)
					vsum_q <= vsum_q
						+ apply_sign(jerk_q[COEF_WIDTH-1], 64'(mul_rsp.prod[94:33]));
			end
			ST_VT_MUL: begin
				if (op_done)
					psum_q <= ps_shift
						+ apply_sign(start_vel_q[POS_WIDTH-1], mul_rsp.prod[63:0]);
			end
			ST_AT2_MUL: begin
				if (op_done)
					psum_q <= psum_q
						+ apply_sign(accel_q[COEF_WIDTH-1], 64'(mul_rsp.prod[94:33]));
			end
			ST_JT3_MUL: if (op_done) wrk_q <= jt3_term;
			ST_DIV6: begin
				if (op_done)
					psum_q <= psum_q + apply_sign(jerk_q[COEF_WIDTH-1], 64'(div_rsp.quo));
			end
			ST_FINISH: begin
				pos_q <= fin_pos(psum_q);
				vel_q <= fin_pos(vsum_q);
			end
			default: ;
		endcase
		if (out_load)
			m_data_q <= {{PAD_WIDTH{1'b0}}, left_q, vel_q, pos_q};
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule
`default_nettype wire

@@ sv/cmpa_mul.sv @@
// Unsigned shift-and-add multiplier, one multiplier bit per cycle.
// Depends on cmpa_pkg for operand widths and request/response structs.
`default_nettype none
module cmpa_mul (
	input  logic                clk,
	input  logic                arst_n,
	input  cmpa_pkg::mul_req_t  req,
	output cmpa_pkg::mul_rsp_t  rsp
);
	import cmpa_pkg::*;

	localparam int CNT_WIDTH = $clog2(OP_WIDTH);

	logic [OP_WIDTH-1:0]   mcand_q;
	logic [OP_WIDTH-1:0]   mplier_q;
	logic [2*OP_WIDTH-1:0] acc_q;
	logic [CNT_WIDTH-1:0]  cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [OP_WIDTH:0]     sum;

	assign sum = {1'b0, acc_q[2*OP_WIDTH-1:OP_WIDTH]}
		+ (mplier_q[0] ? {1'b0, mcand_q} : {(OP_WIDTH+1){1'b0}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_WIDTH'(OP_WIDTH - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			mcand_q  <= req.a;
			mplier_q <= req.b;
			acc_q    <= '0;
		end else if (busy_q) begin
			// add the partial product at the top, shift the whole word down
			acc_q    <= {sum, acc_q[OP_WIDTH-1:1]};
			mplier_q <= {1'b0, mplier_q[OP_WIDTH-1:1]};
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = acc_q;

endmodule
`default_nettype wire

@@ sv/cmpa_div.sv @@
// Restoring divider, one quotient bit per cycle, with low zero bits appended to the
// dividend and a saturating quotient. Depends on cmpa_pkg.
`default_nettype none
module cmpa_div (
	input  logic                clk,
	input  logic                arst_n,
	input  cmpa_pkg::div_req_t  req,
	output cmpa_pkg::div_rsp_t  rsp
);
	import cmpa_pkg::*;

	logic [OP_WIDTH-1:0]      num_q;
	logic [TIME_WIDTH-1:0]    den_q;
	logic [TIME_WIDTH-1:0]    rem_q;
	logic [QUO_WIDTH-1:0]     quo_q;
	logic                     ovf_q;
	logic [DIV_CNT_WIDTH-1:0] cnt_q;
	logic [DIV_CNT_WIDTH-1:0] last_q;
	logic                     busy_q;
	logic                     done_q;
	logic [TIME_WIDTH:0]      rem2;
	logic [TIME_WIDTH:0]      diff;
	logic                     ge;

	assign rem2 = {rem_q, num_q[OP_WIDTH-1]};
	assign diff = rem2 - {1'b0, den_q};
	assign ge   = (rem2 >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == last_q) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q  <= req.num;
			den_q  <= req.den;
			rem_q  <= '0;
			quo_q  <= '0;
			ovf_q  <= 1'b0;
			last_q <= DIV_CNT_WIDTH'(OP_WIDTH) + DIV_CNT_WIDTH'(req.shift) - 1'b1;
		end else if (busy_q) begin
			num_q <= {num_q[OP_WIDTH-2:0], 1'b0};
			rem_q <= ge ? diff[TIME_WIDTH-1:0] : rem2[TIME_WIDTH-1:0];
			quo_q <= {quo_q[QUO_WIDTH-2:0], ge};
			// a set top bit shifted out means the quotient is past the limit
			ovf_q <= ovf_q | quo_q[QUO_WIDTH-1];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = ovf_q ? SATMAG : quo_q;

endmodule
`default_nettype wire

@@ sv/cmpa_checker.sv @@
// Port-level checks for the cubic motion profile axis, bound to the top level.
// Depends on cmpa_pkg for field widths.
`default_nettype none
module cmpa_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  s_axis_tvalid,
	input logic                                  s_axis_tready,
	input logic                                  m_axis_tvalid,
	input logic                                  m_axis_tready,
	input logic [cmpa_pkg::OUT_DATA_WIDTH-1:0]   m_axis_tdata
);
	import cmpa_pkg::*;

	// a waiting word holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output word changed or dropped while stalled");

	// one item in work at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while an item is in work");

	// a new result appears only as the sequencer returns to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> s_axis_tready)
		else $error("result presented while still busy");

	// time left never reaches the most negative code
	a_left_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[2*POS_WIDTH +: LEFT_WIDTH]
			!= {1'b1, {(LEFT_WIDTH-1){1'b0}}})
		else $error("time left out of range");

endmodule

bind cubic_motion_profile_axis cmpa_checker u_cmpa_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
